FILE: hw/rtl/hidrd_pkg.sv
package hidrd_pkg;

  // report storage and counting
  localparam int MAX_REPORT_BYTES = 64;
  localparam int COUNT_WIDTH      = 32;
  localparam int NUM_REPORT_IDS   = 256;
  localparam int KEPT_BYTES       = 13;

  localparam int BCNT_W = $clog2(MAX_REPORT_BYTES + 1);
  localparam int SLOT_W = $clog2(NUM_REPORT_IDS);

  // length thresholds
  localparam int SIX_AXIS_MIN_BYTES = 13;
  localparam int TRIPLE_MIN_BYTES   = 7;
  localparam int BUTTON_MIN_BYTES   = 2;

  // report ids
  localparam logic [7:0] ID_MOTION   = 8'h01;
  localparam logic [7:0] ID_ROTATION = 8'h02;
  localparam logic [7:0] ID_BUTTON_A = 8'h03;
  localparam logic [7:0] ID_MIXED    = 8'h04;
  localparam logic [7:0] ID_BUTTON_B = 8'h05;
  localparam logic [7:0] ID_BUTTON_C = 8'h06;

  typedef enum logic [2:0] {
    KIND_UNHANDLED = 3'd0,
    KIND_SIX_AXIS  = 3'd1,
    KIND_TRANS     = 3'd2,
    KIND_ROT       = 3'd3,
    KIND_BUTTONS   = 3'd4,
    KIND_SHORT     = 3'd5
  } report_kind_e;

  typedef logic [KEPT_BYTES-1:0][7:0] payload_t;
  typedef logic signed [15:0] axis_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  // signed little-endian 16-bit value starting at byte pos
  function automatic axis_t axis_at(payload_t p, int unsigned pos);
    axis_at = axis_t'({p[pos+1], p[pos]});
  endfunction

endpackage

FILE: hw/rtl/hidrd_in_if.sv
interface hidrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: hw/rtl/hidrd_out_if.sv
interface hidrd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] trans_x;
  logic signed [15:0] trans_y;
  logic signed [15:0] trans_z;
  logic signed [15:0] rot_x;
  logic signed [15:0] rot_y;
  logic signed [15:0] rot_z;
  logic [31:0]        button_mask;
  logic [7:0]         report_ident;
  logic [2:0]         report_kind;
  logic [31:0]        id_seen_count;

  modport source (
    output valid, output trans_x, output trans_y, output trans_z,
    output rot_x, output rot_y, output rot_z, output button_mask,
    output report_ident, output report_kind, output id_seen_count,
    input ready
  );
  modport sink (
    input valid, input trans_x, input trans_y, input trans_z,
    input rot_x, input rot_y, input rot_z, input button_mask,
    input report_ident, input report_kind, input id_seen_count,
    output ready
  );
endinterface

FILE: hw/rtl/six_axis_hid_report_decoder_core.sv
// Six-axis HID report decoder. Report bytes enter one per cycle on in_i while in_i.ready is
// high, id byte first, with last_byte set on the final byte; a new report may start right
// after the last byte of the previous one. Bytes without last_byte give no item on out_o.
// For each finished report one item appears once its last byte has passed into the decode
// register, where the per-id counter table's registered read lands, and then into the result
// register, carrying the updated translation, rotation and button registers, the report id,
// its kind and the wrapping count of reports seen with that id. Throughput is one byte per
// cycle while out_o gives no back-pressure. The 256-entry counter table has one registered
// read port, used on the last byte, and one write port, used as the decode register moves on;
// a counter written on the same edge as it is read comes from a bypass instead of the table.
// Counter entries carry valid bits cleared by reset, so no clearing pass is needed after reset.
// Back-pressure on out_o stalls the decode register and then in_i.ready.
module six_axis_hid_report_decoder_core import hidrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hidrd_in_if.sink    in_i,
  hidrd_out_if.source out_o
);

  // byte collection
  payload_t              payload_q;
  payload_t              payload_mrg;
  logic [BCNT_W-1:0]     bcnt_q, bcnt_d, bcnt_inc;
  logic                  in_acc, in_last;
  logic [7:0]            rd_id;

  // decode register, one finished report
  logic                  s1_vld_q;
  payload_t              s1_pay_q;
  logic [BCNT_W-1:0]     s1_len_q;
  logic                  s1_hit_q;
  count_t                s1_fwd_q;
  logic                  s1_fire;

  // per-id counter table
  count_t                cnt_mem [NUM_REPORT_IDS];
  logic [NUM_REPORT_IDS-1:0] cnt_vld_q;
  count_t                rd_data_q;
  logic                  rd_vld_q;
  count_t                cnt_base, cnt_next;
  logic [SLOT_W-1:0]     rd_slot, wr_slot;

  // decoded state and result register
  axis_t                 trans_q [3];
  axis_t                 rot_q [3];
  axis_t                 trans_d [3];
  axis_t                 rot_d [3];
  logic [31:0]           btn_q, btn_d;
  report_kind_e          kind_d, kind_q;
  logic                  out_vld_q;
  logic [7:0]            ident_q;
  count_t                seen_q;

  assign in_acc  = in_i.valid && in_i.ready;
  assign in_last = in_acc && in_i.last_byte;

  // the decode register moves on whenever the result slot is free or being taken
  assign s1_fire    = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || s1_fire;

  // drop the incoming byte into its slot of the kept bytes
  always_comb begin
    for (int i = 0; i < KEPT_BYTES; i++) begin
      payload_mrg[i] = (bcnt_q == BCNT_W'(i)) ? in_i.data_byte : payload_q[i];
    end
  end

  // saturating length count, cleared after the last byte
  assign bcnt_inc = (bcnt_q < BCNT_W'(MAX_REPORT_BYTES)) ? bcnt_q + 1'b1 : bcnt_q;
  assign bcnt_d   = in_i.last_byte ? '0 : bcnt_inc;

  // id of the report being finished, for the counter lookup
  assign rd_id   = (bcnt_q == '0) ? in_i.data_byte : payload_q[0];
  assign rd_slot = rd_id[SLOT_W-1:0];
  assign wr_slot = s1_pay_q[0][SLOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q <= '0;
    end else if (in_acc) begin
      bcnt_q <= bcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      payload_q <= payload_mrg;
    end
  end

  // decode register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_last) begin
      s1_vld_q <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_q <= 1'b0;
    end
  end

  // decode register payload; catch a write to the same slot on the read edge
  always_ff @(posedge clk_i) begin
    if (in_last) begin
      s1_pay_q <= payload_mrg;
      s1_len_q <= bcnt_inc;
      s1_hit_q <= s1_fire && (wr_slot == rd_slot);
      s1_fwd_q <= cnt_next;
    end
  end

  // counter table: registered read at the last byte, write when decoding
  always_ff @(posedge clk_i) begin
    if (in_last) begin
      rd_data_q <= cnt_mem[rd_slot];
    end
    if (s1_fire) begin
      cnt_mem[wr_slot] <= cnt_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (in_last) begin
        rd_vld_q <= cnt_vld_q[rd_slot];
      end
      if (s1_fire) begin
        cnt_vld_q[wr_slot] <= 1'b1;
      end
    end
  end

  // an entry never written reads as zero; counters wrap
  assign cnt_base = s1_hit_q ? s1_fwd_q : (rd_vld_q ? rd_data_q : '0);
  assign cnt_next = cnt_base + 1'b1;

  // report decode by id and length
  always_comb begin
    axis_t t [3];
    axis_t r [3];
    logic  t_zero;
    logic  r_zero;
    logic [31:0] btn_load;

    for (int k = 0; k < 3; k++) begin
      t[k]       = axis_at(s1_pay_q, 1 + 2 * k);
      r[k]       = axis_at(s1_pay_q, 7 + 2 * k);
      trans_d[k] = trans_q[k];
      rot_d[k]   = rot_q[k];
    end
    t_zero = (t[0] == '0) && (t[1] == '0) && (t[2] == '0);
    r_zero = (r[0] == '0) && (r[1] == '0) && (r[2] == '0);
    btn_d  = btn_q;

    // missing button bytes are zero
    btn_load = {s1_pay_q[4], s1_pay_q[3], s1_pay_q[2], s1_pay_q[1]};
    if (s1_len_q < BCNT_W'(5)) begin
      btn_load[31:24] = '0;
    end
    if (s1_len_q < BCNT_W'(4)) begin
      btn_load[23:16] = '0;
    end
    if (s1_len_q < BCNT_W'(3)) begin
      btn_load[15:8] = '0;
    end

    kind_d = KIND_UNHANDLED;
    unique case (s1_pay_q[0]) inside
      ID_MOTION: begin
        if (s1_len_q >= BCNT_W'(SIX_AXIS_MIN_BYTES)) begin
          kind_d = KIND_SIX_AXIS;
          for (int k = 0; k < 3; k++) begin
            // a lone nonzero half drives both registers
            if (r_zero && !t_zero) begin
              trans_d[k] = t[k];
              rot_d[k]   = t[k];
            end else if (t_zero && !r_zero) begin
              trans_d[k] = r[k];
              rot_d[k]   = r[k];
            end else begin
              trans_d[k] = t[k];
              rot_d[k]   = r[k];
            end
          end
        end else if (s1_len_q >= BCNT_W'(TRIPLE_MIN_BYTES)) begin
          kind_d = KIND_TRANS;
          for (int k = 0; k < 3; k++) begin
            trans_d[k] = t[k];
          end
        end else begin
          kind_d = KIND_SHORT;
        end
      end
      ID_ROTATION: begin
        if (s1_len_q >= BCNT_W'(TRIPLE_MIN_BYTES)) begin
          kind_d = KIND_ROT;
          for (int k = 0; k < 3; k++) begin
            rot_d[k] = t[k];
          end
        end else begin
          kind_d = KIND_SHORT;
        end
      end
      ID_BUTTON_A, ID_BUTTON_B, ID_BUTTON_C: begin
        if (s1_len_q >= BCNT_W'(BUTTON_MIN_BYTES)) begin
          kind_d = KIND_BUTTONS;
          btn_d  = btn_load;
        end else begin
          kind_d = KIND_SHORT;
        end
      end
      ID_MIXED: begin
        if (s1_len_q >= BCNT_W'(TRIPLE_MIN_BYTES)) begin
          kind_d = KIND_ROT;
          for (int k = 0; k < 3; k++) begin
            rot_d[k] = t[k];
          end
        end else if (s1_len_q >= BCNT_W'(BUTTON_MIN_BYTES)) begin
          kind_d = KIND_BUTTONS;
          btn_d  = btn_load;
        end else begin
          kind_d = KIND_SHORT;
        end
      end
      default: begin
        kind_d = KIND_UNHANDLED;
      end
    endcase
  end

  // axis and button registers double as the result fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        trans_q[k] <= '0;
        rot_q[k]   <= '0;
      end
      btn_q <= '0;
    end else if (s1_fire) begin
      for (int k = 0; k < 3; k++) begin
        trans_q[k] <= trans_d[k];
        rot_q[k]   <= rot_d[k];
      end
      btn_q <= btn_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      ident_q <= s1_pay_q[0];
      kind_q  <= kind_d;
      seen_q  <= cnt_next;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.trans_x       = trans_q[0];
  assign out_o.trans_y       = trans_q[1];
  assign out_o.trans_z       = trans_q[2];
  assign out_o.rot_x         = rot_q[0];
  assign out_o.rot_y         = rot_q[1];
  assign out_o.rot_z         = rot_q[2];
  assign out_o.button_mask   = btn_q;
  assign out_o.report_ident  = ident_q;
  assign out_o.report_kind   = 3'(kind_q);
  assign out_o.id_seen_count = 32'(seen_q);

`ifndef ASSERT_OFF
  a_bcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= BCNT_W'(MAX_REPORT_BYTES))
    else $error("byte count above saturation limit");

  a_bcnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_last |=> bcnt_q == '0)
    else $error("byte count not cleared after last byte");

  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_vld_q)
    else $error("decoded report did not reach result register");

  a_six_axis_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && kind_q == KIND_SIX_AXIS) |-> ident_q == ID_MOTION)
    else $error("six-axis kind with wrong id");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !s1_fire) |-> !in_last)
    else $error("report finished while decode register stalled");
`endif

endmodule
